// ===== rtl/core/snip_pkg.sv =====
package snip_pkg;

    localparam int ROW_BITS  = 8;
    localparam int COL_BITS  = 8;
    localparam int ADDR_BITS = ROW_BITS + COL_BITS;
    localparam int DEPTH     = 1 << ADDR_BITS;
    localparam int PIX_BITS  = 32;
    localparam int SIZE_BITS = 9;
    localparam int WIN_BITS  = 7;
    localparam int TAPS      = 9;
    localparam int TAP_BITS  = 4;
    localparam logic [SIZE_BITS-1:0] MAX_SIZE = 9'd256;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        CFG_ROWS  = 2'd0,
        CFG_COLS  = 2'd1,
        CFG_WIDTH = 2'd2
    } t_cfg_index;

    // tap order inside the window
    localparam logic [TAP_BITS-1:0] TAP_CENTER = 4'd0;
    localparam logic [TAP_BITS-1:0] TAP_P4     = 4'd1;
    localparam logic [TAP_BITS-1:0] TAP_S4     = 4'd2;
    localparam logic [TAP_BITS-1:0] TAP_P2     = 4'd3;
    localparam logic [TAP_BITS-1:0] TAP_S3     = 4'd4;
    localparam logic [TAP_BITS-1:0] TAP_S2     = 4'd5;
    localparam logic [TAP_BITS-1:0] TAP_P3     = 4'd6;
    localparam logic [TAP_BITS-1:0] TAP_S1     = 4'd7;
    localparam logic [TAP_BITS-1:0] TAP_P1     = 4'd8;

    typedef struct packed {
        logic [1:0]          action;
        logic [ROW_BITS-1:0] row_index;
        logic [COL_BITS-1:0] column_index;
        logic [PIX_BITS-1:0] pixel_value;
    } t_in_item;

    typedef struct packed {
        logic                result_kind;
        logic [PIX_BITS-1:0] read_value;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN_LOAD,
        ST_PASS_CHECK,
        ST_FETCH,
        ST_FETCH_WAIT,
        ST_CALC_SIDES,
        ST_CALC_EST,
        ST_COMMIT_RD,
        ST_COMMIT_WR,
        ST_NEXT_PASS,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic host_wr;
        logic host_rd;
        logic load_p;
        logic dec_p;
        logic init_ij;
        logic fetch;
        logic calc_sides;
        logic calc_est;
        logic commit_rd;
        logic commit_wr;
        logic step;
        logic done;
    } t_ctrl_cmd;

    typedef struct packed {
        logic p_zero;
        logic pass_empty;
        logic k_last;
        logic ij_last;
    } t_ctrl_status;

endpackage

// ===== rtl/core/snip_ram.sv =====
module snip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/snip_ctrl.sv =====
module snip_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [1:0]            i_action,
    input  snip_pkg::t_ctrl_status i_status,
    output snip_pkg::t_ctrl_cmd   o_cmd,
    output logic                  busy
);
    import snip_pkg::*;

    t_state r_state, n_state;
    logic   accept;

    assign accept = start && (r_state == ST_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_action == ACT_RUN) n_state = ST_RUN_LOAD;
            end
            ST_RUN_LOAD:   n_state = ST_PASS_CHECK;
            ST_PASS_CHECK: begin
                if (i_status.p_zero) n_state = ST_DONE;
                else if (i_status.pass_empty) n_state = ST_NEXT_PASS;
                else n_state = ST_FETCH;
            end
            ST_FETCH: begin
                if (i_status.k_last) n_state = ST_FETCH_WAIT;
            end
            ST_FETCH_WAIT: n_state = ST_CALC_SIDES;
            ST_CALC_SIDES: n_state = ST_CALC_EST;
            ST_CALC_EST: begin
                n_state = i_status.ij_last ? ST_COMMIT_RD : ST_FETCH;
            end
            ST_COMMIT_RD:  n_state = ST_COMMIT_WR;
            ST_COMMIT_WR: begin
                n_state = i_status.ij_last ? ST_NEXT_PASS : ST_COMMIT_RD;
            end
            ST_NEXT_PASS:  n_state = ST_PASS_CHECK;
            ST_DONE:       n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.host_wr = accept && i_action == ACT_WRITE;
                o_cmd.host_rd = accept && i_action == ACT_READ;
            end
            ST_RUN_LOAD:   o_cmd.load_p = 1'b1;
            ST_PASS_CHECK: o_cmd.init_ij = !i_status.p_zero && !i_status.pass_empty;
            ST_FETCH:      o_cmd.fetch = 1'b1;
            ST_CALC_SIDES: o_cmd.calc_sides = 1'b1;
            ST_CALC_EST: begin
                o_cmd.calc_est = 1'b1;
                o_cmd.step     = 1'b1;
                o_cmd.init_ij  = i_status.ij_last;
            end
            ST_COMMIT_RD:  o_cmd.commit_rd = 1'b1;
            ST_COMMIT_WR: begin
                o_cmd.commit_wr = 1'b1;
                o_cmd.step      = 1'b1;
            end
            ST_NEXT_PASS:  o_cmd.dec_p = 1'b1;
            ST_DONE:       o_cmd.done = 1'b1;
            default:       o_cmd = '0;
        endcase
    end

    assign busy = (r_state != ST_IDLE);
endmodule

// ===== rtl/core/snip_datapath.sv =====
module snip_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  snip_pkg::t_in_item        i_item,
    input  logic                      i_cfg_valid,
    input  logic [1:0]                i_cfg_index,
    input  logic [snip_pkg::SIZE_BITS-1:0] i_cfg_data,
    input  snip_pkg::t_ctrl_cmd       i_cmd,
    output snip_pkg::t_ctrl_status    o_status,
    output logic                      o_strobe,
    output snip_pkg::t_out_item       o_result
);
    import snip_pkg::*;

    // configuration registers
    logic [SIZE_BITS-1:0] r_rows, r_cols;
    logic [WIN_BITS-1:0]  r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= MAX_SIZE;
            r_cols  <= MAX_SIZE;
            r_width <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROWS:  r_rows  <= i_cfg_data;
                CFG_COLS:  r_cols  <= i_cfg_data;
                CFG_WIDTH: r_width <= i_cfg_data[WIN_BITS-1:0];
                default:   ;
            endcase
        end
    end

    logic [SIZE_BITS-1:0] rows_eff, cols_eff;
    assign rows_eff = (r_rows < MAX_SIZE) ? r_rows : MAX_SIZE;
    assign cols_eff = (r_cols < MAX_SIZE) ? r_cols : MAX_SIZE;

    // window counter and scan position
    logic [WIN_BITS-1:0] r_p;
    logic [ROW_BITS-1:0] r_i;
    logic [COL_BITS-1:0] r_j;
    logic [TAP_BITS-1:0] r_k;
    logic                row_end, col_end;

    assign row_end = ({1'b0, r_i} + {2'b0, r_p} + 9'd1) == rows_eff;
    assign col_end = ({1'b0, r_j} + {2'b0, r_p} + 9'd1) == cols_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= '0;
        end else if (i_cmd.load_p) begin
            r_p <= r_width;
        end else if (i_cmd.dec_p) begin
            r_p <= r_p - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_ij) begin
            r_i <= ROW_BITS'(r_p);
            r_j <= COL_BITS'(r_p);
        end else if (i_cmd.step) begin
            if (col_end) begin
                r_j <= COL_BITS'(r_p);
                r_i <= r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.init_ij || i_cmd.calc_sides) begin
            r_k <= '0;
        end else if (i_cmd.fetch) begin
            r_k <= r_k + 1'b1;
        end
    end

    assign o_status.p_zero     = (r_p == '0);
    assign o_status.pass_empty = (rows_eff <= {1'b0, r_p, 1'b0}) ||
                                 (cols_eff <= {1'b0, r_p, 1'b0});
    assign o_status.k_last     = (r_k == TAP_P1);
    assign o_status.ij_last    = row_end && col_end;

    // window tap address
    logic [ROW_BITS-1:0]  tap_row, row_lo, row_hi;
    logic [COL_BITS-1:0]  tap_col, col_lo, col_hi;
    logic [ADDR_BITS-1:0] tap_addr, pos_addr;

    assign row_lo = r_i - ROW_BITS'(r_p);
    assign row_hi = r_i + ROW_BITS'(r_p);
    assign col_lo = r_j - COL_BITS'(r_p);
    assign col_hi = r_j + COL_BITS'(r_p);

    always_comb begin
        tap_row = r_i;
        tap_col = r_j;
        case (r_k)
            TAP_CENTER: begin tap_row = r_i;    tap_col = r_j;    end
            TAP_P4:     begin tap_row = row_lo; tap_col = col_lo; end
            TAP_S4:     begin tap_row = row_lo; tap_col = r_j;    end
            TAP_P2:     begin tap_row = row_lo; tap_col = col_hi; end
            TAP_S3:     begin tap_row = r_i;    tap_col = col_lo; end
            TAP_S2:     begin tap_row = r_i;    tap_col = col_hi; end
            TAP_P3:     begin tap_row = row_hi; tap_col = col_lo; end
            TAP_S1:     begin tap_row = row_hi; tap_col = r_j;    end
            TAP_P1:     begin tap_row = row_hi; tap_col = col_hi; end
            default:    begin tap_row = r_i;    tap_col = r_j;    end
        endcase
    end

    assign tap_addr = {tap_row, tap_col};
    assign pos_addr = {r_i, r_j};

    // pixel and pass memories
    logic                 pix_we;
    logic [ADDR_BITS-1:0] pix_waddr, pix_raddr;
    logic [PIX_BITS-1:0]  pix_wdata, pix_q, pass_q, pass_wdata;

    assign pix_we    = i_cmd.host_wr || i_cmd.commit_wr;
    assign pix_waddr = i_cmd.host_wr ? {i_item.row_index, i_item.column_index} : pos_addr;
    assign pix_wdata = i_cmd.host_wr ? i_item.pixel_value : pass_q;
    assign pix_raddr = i_cmd.host_rd ? {i_item.row_index, i_item.column_index} : tap_addr;

    snip_ram #(.WIDTH(PIX_BITS), .DEPTH(DEPTH)) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (pix_wdata),
        .i_raddr (pix_raddr),
        .o_rdata (pix_q)
    );

    snip_ram #(.WIDTH(PIX_BITS), .DEPTH(DEPTH)) u_pass_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.calc_est),
        .i_waddr (pos_addr),
        .i_wdata (pass_wdata),
        .i_raddr (pos_addr),
        .o_rdata (pass_q)
    );

    // tap capture, in the cycle after the read address is given
    logic [PIX_BITS-1:0] r_tap [TAPS];
    logic                r_cap_en;
    logic [TAP_BITS-1:0] r_cap_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_en <= 1'b0;
        end else begin
            r_cap_en <= i_cmd.fetch;
        end
        r_cap_idx <= r_k;
        if (r_cap_en) begin
            r_tap[r_cap_idx] <= pix_q;
        end
    end

    // clipped side terms
    function automatic logic [PIX_BITS-1:0] side_term(
        input logic [PIX_BITS-1:0] s,
        input logic [PIX_BITS-1:0] ca,
        input logic [PIX_BITS-1:0] cb
    );
        logic [PIX_BITS:0]   sum;
        logic [PIX_BITS-1:0] half;
        sum  = {1'b0, ca} + {1'b0, cb};
        half = sum[PIX_BITS:1];
        return (s > half) ? (s - half) : '0;
    endfunction

    logic [PIX_BITS-1:0] r_side [4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_sides) begin
            r_side[0] <= side_term(r_tap[TAP_S1], r_tap[TAP_P1], r_tap[TAP_P3]);
            r_side[1] <= side_term(r_tap[TAP_S2], r_tap[TAP_P1], r_tap[TAP_P2]);
            r_side[2] <= side_term(r_tap[TAP_S3], r_tap[TAP_P3], r_tap[TAP_P4]);
            r_side[3] <= side_term(r_tap[TAP_S4], r_tap[TAP_P2], r_tap[TAP_P4]);
        end
    end

    // estimate and clip against the centre
    logic [PIX_BITS+1:0] side_sum, corner_sum;
    logic [PIX_BITS+2:0] est;

    assign side_sum   = {2'b0, r_side[0]} + {2'b0, r_side[1]}
                      + {2'b0, r_side[2]} + {2'b0, r_side[3]};
    assign corner_sum = {2'b0, r_tap[TAP_P1]} + {2'b0, r_tap[TAP_P2]}
                      + {2'b0, r_tap[TAP_P3]} + {2'b0, r_tap[TAP_P4]};
    assign est        = {2'b0, side_sum[PIX_BITS+1:1]} + {3'b0, corner_sum[PIX_BITS+1:2]};
    assign pass_wdata = (est < {3'b0, r_tap[TAP_CENTER]}) ? est[PIX_BITS-1:0]
                                                          : r_tap[TAP_CENTER];

    // result strobe
    logic r_rd_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.host_rd;
        end
    end

    assign o_strobe             = r_rd_pend || i_cmd.done;
    assign o_result.result_kind = i_cmd.done;
    assign o_result.read_value  = r_rd_pend ? pix_q : '0;
endmodule

// ===== rtl/core/snip_2d_background_estimator.sv =====
// SNIP background estimator for a 2D image held in on-chip memory.
// Command channel: an item is taken on a rising edge with start high and
// busy low. Write items store a pixel in that cycle and give no result.
// Read items give one result, read data, on o_strobe in the next cycle;
// reads and writes can be issued every cycle.
// Run items raise busy and sweep the clipping passes from clip_width
// down to one. Each pixel of a pass takes nine window reads through
// the single pixel-memory read port, a wait for the registered read
// data, the side terms and then the estimate, which goes to the scratch
// memory; after the last pixel of the pass each is committed back from
// it by a read and a write. When a run is done, a run finished result
// shows on o_strobe for one cycle with busy still high.
// Results are shown for exactly one cycle; the receiver cannot stall.
// Configuration writes are always taken (o_cfg_ready stays high) and are
// meant for idle time only. Reset returns the controller to idle and
// the registers to 256 rows, 256 columns, width zero; memory contents
// are undefined until written.
module snip_2d_background_estimator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  snip_pkg::t_in_item            i_item,
    output logic                          o_strobe,
    output snip_pkg::t_out_item           o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [snip_pkg::SIZE_BITS-1:0] i_cfg_data
);
    import snip_pkg::*;

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    assign o_cfg_ready = 1'b1;

    snip_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_item.action),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    snip_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    // a read transaction is answered in the next cycle
    a_read_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == ACT_READ)
        |=> (o_strobe && !o_result.result_kind))
        else $error("read transaction not answered");

    // a run transaction makes the block busy
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == ACT_RUN) |=> busy)
        else $error("run transaction did not raise busy");

    // run finished only while busy and with zero data
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.result_kind) |-> (busy && o_result.read_value == '0))
        else $error("bad run finished result");

    // run finished ends the busy period
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.result_kind) |=> !busy)
        else $error("busy after run finished");
endmodule
